// ----- hw/rtl/rhht_pkg.sv -----
// ----------------------------------------------------------------------------
// rhht_pkg
// Shared types, sizes and codes for the Robin Hood hash table unit.
// ----------------------------------------------------------------------------
package rhht_pkg;

  // table geometry
  localparam int SLOT_BITS      = 10;
  localparam int BUCKET_SLOTS   = 4;
  localparam int OVERFLOW_SLOTS = 32;
  localparam int TOTAL_SLOTS    = (1 << SLOT_BITS) + OVERFLOW_SLOTS;
  localparam int ADDR_W         = $clog2(TOTAL_SLOTS);
  localparam int BSHIFT         = $clog2(BUCKET_SLOTS);
  // slot pointer also holds the end of a bucket scan (up to 15 buckets past home)
  localparam int PTR_W          = $clog2(TOTAL_SLOTS + 16 * BUCKET_SLOTS);
  localparam int DIFF_W         = PTR_W + 1;
  localparam int CNT_W          = $clog2(TOTAL_SLOTS + 1);

  // spans and limits
  localparam int SSPAN_W   = 6;
  localparam int BSPAN_W   = 4;
  localparam int FILL_W    = 7;
  localparam int SSPAN_MAX = 63;
  localparam int BSPAN_MAX = 15;
  localparam int PCT_SCALE = 100;
  localparam int GROW_W    = CNT_W + FILL_W + 1;

  // register file
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_SLOT_LIM = 2'd0;
  localparam logic [1:0] REG_BKT_LIM  = 2'd1;
  localparam logic [1:0] REG_FILL_LIM = 2'd2;

  // actions
  localparam logic [1:0] ACT_FIND   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXISTS    = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_GROW      = 2'd3;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] val;
  } entry_t;

  typedef struct packed {
    logic [SSPAN_W-1:0] slot_lim;
    logic [BSPAN_W-1:0] bkt_lim;
    logic [FILL_W-1:0]  fill_lim;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOC_RD,
    ST_LOC_CHK,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_DONE
  } state_t;

  // home slot of a key
  function automatic logic [SLOT_BITS-1:0] home_of(input logic [63:0] h);
    home_of = h[63 -: SLOT_BITS];
  endfunction

endpackage

// ----- hw/rtl/rhht_mem.sv -----
// ----------------------------------------------------------------------------
// rhht_mem
// Single-port-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rhht_mem #(
  parameter int DEPTH = 1056,
  parameter int WIDTH = 192,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rhht_cfg.sv -----
// ----------------------------------------------------------------------------
// rhht_cfg
// APB register file holding the growth limits.
// ----------------------------------------------------------------------------
module rhht_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rhht_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rhht_pkg::cfg_t             cfg
);
  import rhht_pkg::*;

  logic [SSPAN_W-1:0] slot_lim_r;
  logic [BSPAN_W-1:0] bkt_lim_r;
  logic [FILL_W-1:0]  fill_lim_r;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_lim_r <= SSPAN_W'(16);
      bkt_lim_r  <= BSPAN_W'(4);
      fill_lim_r <= FILL_W'(90);
    end else if (wr_en) begin
      case (reg_idx)
        REG_SLOT_LIM: slot_lim_r <= pwdata[SSPAN_W-1:0];
        REG_BKT_LIM:  bkt_lim_r  <= pwdata[BSPAN_W-1:0];
        REG_FILL_LIM: fill_lim_r <= pwdata[FILL_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_SLOT_LIM: prdata = 32'(slot_lim_r);
      REG_BKT_LIM:  prdata = 32'(bkt_lim_r);
      REG_FILL_LIM: prdata = 32'(fill_lim_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.slot_lim = slot_lim_r;
  assign cfg.bkt_lim  = bkt_lim_r;
  assign cfg.fill_lim = fill_lim_r;

endmodule

// ----- hw/rtl/rhht_ctrl.sv -----
// ----------------------------------------------------------------------------
// rhht_ctrl
// Sequencer: bucket scan, Robin Hood walk, backward-shift delete, spans.
// ----------------------------------------------------------------------------
module rhht_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rhht_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_action,
  input  logic [63:0]                in_hash_high,
  input  logic [63:0]                in_hash_low,
  input  logic [63:0]                in_value_in,
  input  logic                       in_overwrite,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic                       out_found,
  output logic [63:0]                out_value_out,
  output logic                       mem_we,
  output logic [rhht_pkg::ADDR_W-1:0] mem_waddr,
  output rhht_pkg::entry_t           mem_wdata,
  output logic [rhht_pkg::ADDR_W-1:0] mem_raddr,
  input  rhht_pkg::entry_t           mem_rdata
);
  import rhht_pkg::*;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [63:0]         hi_r, hi_nxt, lo_r, lo_nxt, v_r, v_nxt;
  logic                ow_r, ow_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt, end_r, end_nxt;
  entry_t              chi_r, chi_nxt;
  logic                orig_r, orig_nxt, commit_r, commit_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SSPAN_W-1:0]  sspan_r, sspan_nxt;
  logic [BSPAN_W-1:0]  bspan_r, bspan_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                res_found_r, res_found_nxt;
  logic [63:0]         res_value_r, res_value_nxt;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic                out_found_r;
  logic [63:0]         out_value_r;

  logic                in_fire, out_free;
  logic                ptr_end, scan_done, n_end;
  logic [PTR_W-1:0]    nxt_ptr, bkt_start;
  logic                occ, key_match, shift_ok, key_zero, grow_now;
  logic signed [DIFF_W-1:0] curd, newd, d_abs, bdiff, bd_abs;
  logic                displace, walk_far;
  logic [SSPAN_W-1:0]  ns;
  logic [BSPAN_W-1:0]  nb;
  logic [GROW_W-1:0]   fill_lhs, fill_rhs;

  assign in_fire  = in_valid & ~in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = ~out_valid_r | ~out_stall;

  // probe decode
  always_comb begin
    nxt_ptr   = ptr_r + PTR_W'(1);
    ptr_end   = ptr_r >= PTR_W'(TOTAL_SLOTS);
    scan_done = ptr_r >= end_r;
    n_end     = nxt_ptr >= PTR_W'(TOTAL_SLOTS);
    bkt_start = PTR_W'({home_of(in_hash_high) >> BSHIFT, BSHIFT'(0)});
    occ       = |mem_rdata;
    key_match = occ && (mem_rdata.hi == hi_r) && (mem_rdata.lo == lo_r);
    shift_ok  = occ && (PTR_W'(home_of(mem_rdata.hi)) < nxt_ptr);
    key_zero  = ~|{hi_r, lo_r, v_r};
    curd      = $signed({1'b0, ptr_r}) - $signed(DIFF_W'(home_of(mem_rdata.hi)));
    newd      = $signed({1'b0, ptr_r}) - $signed(DIFF_W'(home_of(chi_r.hi)));
    displace  = newd > curd;
    walk_far  = curd >= $signed(DIFF_W'(cfg.slot_lim));
    d_abs     = (newd < 0) ? -newd : newd;
    bdiff     = $signed(DIFF_W'(ptr_r >> BSHIFT))
              - $signed(DIFF_W'(home_of(chi_r.hi) >> BSHIFT));
    bd_abs    = (bdiff < 0) ? -bdiff : bdiff;
    ns = (d_abs >= $signed(DIFF_W'(SSPAN_MAX))) ? SSPAN_W'(SSPAN_MAX)
                                                 : SSPAN_W'(d_abs + DIFF_W'(1));
    nb = (bd_abs >= $signed(DIFF_W'(BSPAN_MAX))) ? BSPAN_W'(BSPAN_MAX)
                                                  : BSPAN_W'(bd_abs + DIFF_W'(1));
    fill_lhs  = GROW_W'(count_r) * GROW_W'(PCT_SCALE);
    fill_rhs  = GROW_W'(cfg.fill_lim) * GROW_W'(TOTAL_SLOTS);
    grow_now  = (sspan_r > cfg.slot_lim) || (bspan_r > cfg.bkt_lim) || (fill_lhs > fill_rhs);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == ADDR_W'(TOTAL_SLOTS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_FIND, ACT_DELETE: state_nxt = ST_LOC_RD;
            ACT_INSERT:           state_nxt = grow_now ? ST_DONE : ST_WALK_RD;
            default:              state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LOC_RD:  state_nxt = (scan_done || ptr_end) ? ST_DONE : ST_LOC_CHK;
      ST_LOC_CHK: begin
        if (key_match) state_nxt = (op_r == ACT_FIND) ? ST_DONE : ST_DEL_RD;
        else           state_nxt = ST_LOC_RD;
      end
      ST_DEL_RD:  state_nxt = n_end ? ST_DONE : ST_DEL_CHK;
      ST_DEL_CHK: state_nxt = shift_ok ? ST_DEL_RD : ST_DONE;
      ST_WALK_RD: state_nxt = ptr_end ? ST_DONE : ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (!occ)                      state_nxt = (commit_r || key_zero) ? ST_DONE : ST_WALK_RD;
        else if (orig_r && key_match)  state_nxt = (ow_r && key_zero) ? ST_DEL_RD : ST_DONE;
        else if (walk_far)             state_nxt = ST_DONE;
        else                           state_nxt = ST_WALK_RD;
      end
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    hi_nxt         = hi_r;
    lo_nxt         = lo_r;
    v_nxt          = v_r;
    ow_nxt         = ow_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    chi_nxt        = chi_r;
    orig_nxt       = orig_r;
    commit_nxt     = commit_r;
    count_nxt      = count_r;
    sspan_nxt      = sspan_r;
    bspan_nxt      = bspan_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r[ADDR_W-1:0];
    mem_wdata      = '0;
    mem_raddr      = ptr_r[ADDR_W-1:0];
    case (state_r)
      // zero the table after reset
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_action;
          hi_nxt         = in_hash_high;
          lo_nxt         = in_hash_low;
          v_nxt          = in_value_in;
          ow_nxt         = in_overwrite;
          res_status_nxt = STAT_NOT_FOUND;
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          if (in_action == ACT_INSERT) begin
            ptr_nxt    = PTR_W'(home_of(in_hash_high));
            chi_nxt    = '{hi: in_hash_high, lo: in_hash_low, val: in_value_in};
            orig_nxt   = 1'b1;
            commit_nxt = 1'b0;
            if (grow_now) res_status_nxt = STAT_GROW;
          end else begin
            ptr_nxt = bkt_start;
            end_nxt = bkt_start + (PTR_W'(bspan_r) << BSHIFT);
          end
        end
      end
      ST_LOC_CHK: begin
        if (key_match) begin
          if (op_r == ACT_FIND) begin
            res_status_nxt = STAT_OK;
            res_found_nxt  = 1'b1;
            res_value_nxt  = mem_rdata.val;
          end
        end else begin
          ptr_nxt = nxt_ptr;
        end
      end
      // backward shift
      ST_DEL_RD: begin
        mem_raddr = nxt_ptr[ADDR_W-1:0];
        if (n_end) begin
          mem_we         = 1'b1;
          res_status_nxt = STAT_OK;
          if (count_r != '0) count_nxt = count_r - CNT_W'(1);
        end
      end
      ST_DEL_CHK: begin
        mem_we = 1'b1;
        if (shift_ok) begin
          mem_wdata = mem_rdata;
          ptr_nxt   = nxt_ptr;
        end else begin
          res_status_nxt = STAT_OK;
          if (count_r != '0) count_nxt = count_r - CNT_W'(1);
        end
      end
      ST_WALK_RD: begin
        if (ptr_end) res_status_nxt = STAT_GROW;
      end
      // Robin Hood walk: dry run first, then the committing run
      ST_WALK_CHK: begin
        if (!occ) begin
          if (commit_r) begin
            mem_we         = 1'b1;
            mem_wdata      = chi_r;
            sspan_nxt      = (ns > sspan_r) ? ns : sspan_r;
            bspan_nxt      = (nb > bspan_r) ? nb : bspan_r;
            count_nxt      = count_r + CNT_W'(1);
            res_status_nxt = STAT_OK;
          end else if (key_zero) begin
            res_status_nxt = STAT_OK;
          end else begin
            commit_nxt = 1'b1;
            ptr_nxt    = PTR_W'(home_of(hi_r));
            chi_nxt    = '{hi: hi_r, lo: lo_r, val: v_r};
            orig_nxt   = 1'b1;
          end
        end else if (orig_r && key_match) begin
          if (!ow_r) begin
            res_status_nxt = STAT_EXISTS;
          end else if (!key_zero) begin
            mem_we         = 1'b1;
            mem_wdata      = '{hi: mem_rdata.hi, lo: mem_rdata.lo, val: v_r};
            res_status_nxt = STAT_OK;
          end
        end else begin
          if (displace) begin
            if (commit_r) begin
              mem_we    = 1'b1;
              mem_wdata = chi_r;
              sspan_nxt = (ns > sspan_r) ? ns : sspan_r;
              bspan_nxt = (nb > bspan_r) ? nb : bspan_r;
            end
            chi_nxt  = mem_rdata;
            orig_nxt = 1'b0;
          end
          if (walk_far) res_status_nxt = STAT_GROW;
          else          ptr_nxt = nxt_ptr;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      sspan_r     <= '0;
      bspan_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      sspan_r <= sspan_nxt;
      bspan_r <= bspan_nxt;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    v_r          <= v_nxt;
    ow_r         <= ow_nxt;
    ptr_r        <= ptr_nxt;
    end_r        <= end_nxt;
    chi_r        <= chi_nxt;
    orig_r       <= orig_nxt;
    commit_r     <= commit_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_value_out = out_value_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TOTAL_SLOTS))
    else $error("entry count beyond table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !mem_we)
    else $error("table written outside an operation");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result word without a finished operation");

  a_span_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (sspan_r >= $past(sspan_r) && bspan_r >= $past(bspan_r)))
    else $error("span shrank");

endmodule

// ----- hw/rtl/robin_hood_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// robin_hood_hash_table_unit
// Open-addressed Robin Hood hash table with find, insert and backward-shift
// delete over a single 192-bit wide entry RAM.
//
//   port group  | direction | words
//   in_*        | in        | one request word: action, hash, value, overwrite
//   out_*       | out       | one result word per request
//   APB         | in/out    | limit registers at 0x0, 0x4, 0x8
//
// Each probed slot passes through a RAM read state, then a check and
// write-back state; an insert that places a new entry makes two walks.
// After reset a clearing pass zeroes all 1056 entries, with in_stall held
// high; register writes are taken throughout.
// One request is in flight at a time; a finished result waits in the output
// register, and a new request is taken while it is stalled.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [63:0]                 in_hash_high,
  input  logic [63:0]                 in_hash_low,
  input  logic [63:0]                 in_value_in,
  input  logic                        in_overwrite,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic                        out_found,
  output logic [63:0]                 out_value_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rhht_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rhht_pkg::*;

  cfg_t              cfg;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;

  rhht_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rhht_mem #(
    .DEPTH (TOTAL_SLOTS),
    .WIDTH ($bits(entry_t)),
    .AW    (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rhht_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_hash_high  (in_hash_high),
    .in_hash_low   (in_hash_low),
    .in_value_in   (in_value_in),
    .in_overwrite  (in_overwrite),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_value_out (out_value_out),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

endmodule
